>>> rtl/cdt_pkg.sv
// shared types, constants and lookup functions for the countdown timer
// no dependencies; imported by every module of the block

package cdt_pkg;

    // display geometry
    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 2;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(DIGIT_COUNT - 1);

    // field widths
    localparam int SEC_W = 16;
    localparam int BTN_W = 4;
    localparam int SEG_W = 7;
    localparam int EN_W  = 4;
    localparam int CFG_W = 16;

    // button bit positions in button_levels
    localparam int BTN_RESET = 0;
    localparam int BTN_START = 1;
    localparam int BTN_PLUS1 = 2;
    localparam int BTN_PLUS10 = 3;

    // configuration register indexes
    localparam logic CFG_MAX_SCAN = 1'b0;
    localparam logic CFG_PRESET   = 1'b1;

    // reset values
    localparam logic [POS_W-1:0] MAX_POS_RESET = 2'd3;
    localparam logic [SEC_W-1:0] PRESET_RESET  = 16'd0;
    localparam logic [BTN_W-1:0] LEVELS_IDLE   = 4'hF;

    // fixed-point digit extraction: frac bits and reciprocal width
    localparam int FRAC_W  = 36;
    localparam int RECIP_W = 33;
    localparam int PROD_W  = SEC_W + RECIP_W;

    // state handed from the state block to the display decode
    typedef struct packed {
        logic [SEC_W-1:0] seconds;
        logic             running;
        logic [POS_W-1:0] position;
    } cdt_view_t;

    // ceil(2^36 / 10^(pos+1)); the fraction of value/10^(pos+1) times ten gives the digit
    function automatic logic [RECIP_W-1:0] digit_recip(input logic [POS_W-1:0] pos);
        logic [RECIP_W-1:0] r;
        case (pos)
            2'd0:    r = 33'd6871947674;
            2'd1:    r = 33'd687194768;
            2'd2:    r = 33'd68719477;
            2'd3:    r = 33'd6871948;
            default: r = 33'd6871947674;
        endcase
        return r;
    endfunction

    // segments a..g, bit0 is a, active high
    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] digit);
        logic [SEG_W-1:0] s;
        case (digit)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/countdown_timer_seven_segment.sv
// top level of the countdown timer with multiplexed seven-segment output
// depends on cdt_pkg, cdt_state, cdt_digit

// One transaction per scan tick; a new one can be accepted every cycle while
// in_stall is low. An accepted transaction sits in the input register, and
// its state update and digit decode land in the output register once that
// register is free. The input side stalls only while the input register is
// full and the output register holds a result that is itself stalled.
// Configuration writes (index 0 max scan position, index 1 preset seconds)
// take effect at once and should be made only while no transaction is in
// flight.

module countdown_timer_seven_segment (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [cdt_pkg::BTN_W-1:0] button_levels,
    input  logic                      second_tick,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [cdt_pkg::SEG_W-1:0] segment_pattern,
    output logic [cdt_pkg::EN_W-1:0]  digit_enable,
    output logic [cdt_pkg::SEC_W-1:0] seconds_value,
    output logic                      counting_flag
);
    import cdt_pkg::*;

    logic             in_full_reg;
    logic [BTN_W-1:0] levels_reg;
    logic             tick_reg;

    logic             out_full_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [EN_W-1:0]  en_reg;
    logic [SEC_W-1:0] sec_reg;
    logic             run_reg;

    logic             out_free;
    logic             step;
    logic             in_take;

    cdt_view_t        view;
    logic [SEG_W-1:0] seg_next;
    logic [EN_W-1:0]  en_next;

    // handshake
    assign out_free = !out_full_reg || !out_stall;
    assign step     = in_full_reg && out_free;
    assign in_stall = in_full_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_full_reg <= 1'b1;
        end
        else if (step)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            levels_reg <= button_levels;
            tick_reg   <= second_tick;
        end
    end

    // state update
    cdt_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .levels    (levels_reg),
        .tick      (tick_reg),
        .view      (view)
    );

    // digit decode
    cdt_digit u_digit (
        .view     (view),
        .segments (seg_next),
        .enable   (en_next)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (step)
        begin
            out_full_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            seg_reg <= seg_next;
            en_reg  <= en_next;
            sec_reg <= view.seconds;
            run_reg <= view.running;
        end
    end

    assign out_valid       = out_full_reg;
    assign segment_pattern = seg_reg;
    assign digit_enable    = en_reg;
    assign seconds_value   = sec_reg;
    assign counting_flag   = run_reg;

endmodule

>>> rtl/cdt_state.sv
// timer state: seconds count, run flag, button history, scan position, config registers
// depends on cdt_pkg

module cdt_state (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0] cfg_data,
    input  logic                      step,
    input  logic [cdt_pkg::BTN_W-1:0] levels,
    input  logic                      tick,
    output cdt_pkg::cdt_view_t        view
);
    import cdt_pkg::*;

    logic [POS_W-1:0] max_pos_reg;
    logic [SEC_W-1:0] preset_reg;
    logic [SEC_W-1:0] seconds_reg, seconds_next;
    logic             running_reg, running_next;
    logic [BTN_W-1:0] prev_levels_reg;
    logic [POS_W-1:0] scan_pos_reg, scan_pos_next;

    logic [SEC_W-1:0] sec_tick;
    logic             run_tick;
    logic [BTN_W-1:0] pressed;
    logic             run_start;
    logic [3:0]       add_amount;
    logic [SEC_W-1:0] sec_add;
    logic [POS_W-1:0] max_clamped;

    // second tick, then button edges in priority order
    always_comb
    begin
        sec_tick  = (tick && running_reg) ? seconds_reg - 16'd1 : seconds_reg;
        run_tick  = running_reg && (sec_tick != '0);
        pressed   = prev_levels_reg & ~levels;
        run_start = run_tick || (pressed[BTN_START] && (sec_tick != preset_reg));

        add_amount = 4'd0;
        if (!run_start)
        begin
            add_amount = (pressed[BTN_PLUS1] ? 4'd1 : 4'd0)
                       + (pressed[BTN_PLUS10] ? 4'd10 : 4'd0);
        end
        sec_add = sec_tick + {{(SEC_W-4){1'b0}}, add_amount};

        if (pressed[BTN_RESET])
        begin
            seconds_next = preset_reg;
            running_next = 1'b0;
        end
        else
        begin
            seconds_next = sec_add;
            running_next = run_start;
        end
    end

    // scan advance with the maximum clamped to the last digit position
    always_comb
    begin
        max_clamped   = (max_pos_reg > MAX_POS) ? MAX_POS : max_pos_reg;
        scan_pos_next = (scan_pos_reg >= max_clamped) ? '0 : scan_pos_reg + 2'd1;
    end

    // state and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pos_reg     <= MAX_POS_RESET;
            preset_reg      <= PRESET_RESET;
            seconds_reg     <= '0;
            running_reg     <= 1'b0;
            prev_levels_reg <= LEVELS_IDLE;
            scan_pos_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_SCAN: max_pos_reg <= cfg_data[POS_W-1:0];
                    CFG_PRESET:   preset_reg  <= cfg_data[SEC_W-1:0];
                    default:      ;
                endcase
            end
            if (step)
            begin
                seconds_reg     <= seconds_next;
                running_reg     <= running_next;
                prev_levels_reg <= levels;
                scan_pos_reg    <= scan_pos_next;
            end
        end
    end

    // values shown for this transaction
    assign view.seconds  = seconds_next;
    assign view.running  = running_next;
    assign view.position = scan_pos_reg;

endmodule

>>> rtl/cdt_digit.sv
// display decode: picks the decimal digit at the scan position and maps it to segments
// depends on cdt_pkg

module cdt_digit (
    input  cdt_pkg::cdt_view_t        view,
    output logic [cdt_pkg::SEG_W-1:0] segments,
    output logic [cdt_pkg::EN_W-1:0]  enable
);
    import cdt_pkg::*;

    logic [PROD_W-1:0]   prod;
    logic [FRAC_W-1:0]   frac;
    logic [FRAC_W+3:0]   times_ten;
    logic [3:0]          digit;

    // fraction of seconds / 10^(pos+1), times ten, integer part is the digit
    always_comb
    begin
        prod      = PROD_W'(view.seconds) * PROD_W'(digit_recip(view.position));
        frac      = prod[FRAC_W-1:0];
        times_ten = ({4'b0, frac} << 3) + ({4'b0, frac} << 1);
        digit     = times_ten[FRAC_W+3:FRAC_W];
    end

    assign segments = seg_decode(digit);

    // ones digit is the most significant select line (bit 3)
    assign enable = EN_W'(4'b1000 >> view.position);

endmodule

>>> sim/tb_top.sv
// self-checking testbench for countdown_timer_seven_segment: directed table, then random phases
// predicts non-typed transactions from its timer model; depends on cdt_pkg and the rtl

`timescale 1ns / 1ps

module tb_top;

    import cdt_pkg::*;

    // one expected display transaction
    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [EN_W-1:0]  en;
        logic [SEC_W-1:0] sec;
        logic             cnt;
    } display_t;

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_CFG} row_kind_e;

    // one line of the directed table
    typedef struct {
        row_kind_e        kind;
        logic [BTN_W-1:0] levels;
        logic             tick;
        logic             reg_index;
        logic [CFG_W-1:0] reg_value;
        display_t         want;
    } dir_row_t;

    // segments a..g per decimal digit, bit0 is a
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    logic             clk;
    logic             rst_n         = 1'b0;
    logic             cfg_write     = 1'b0;
    logic             cfg_index     = CFG_MAX_SCAN;
    logic [CFG_W-1:0] cfg_data      = '0;
    logic             in_valid      = 1'b0;
    logic             in_stall;
    logic [BTN_W-1:0] button_levels = LEVELS_IDLE;
    logic             second_tick   = 1'b0;
    logic             out_valid;
    logic             out_stall     = 1'b0;
    logic [SEG_W-1:0] segment_pattern;
    logic [EN_W-1:0]  digit_enable;
    logic [SEC_W-1:0] seconds_value;
    logic             counting_flag;

    // timer model state and register copies
    logic [SEC_W-1:0] tm_seconds;
    logic             tm_running;
    logic [BTN_W-1:0] tm_prev_levels;
    logic [POS_W-1:0] tm_scan;
    logic [POS_W-1:0] tm_max_scan;
    logic [SEC_W-1:0] tm_preset;

    display_t pending_displays[$];
    dir_row_t dir_rows[$];
    int       err_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;

    countdown_timer_seven_segment uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .button_levels   (button_levels),
        .second_tick     (second_tick),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .segment_pattern (segment_pattern),
        .digit_enable    (digit_enable),
        .seconds_value   (seconds_value),
        .counting_flag   (counting_flag)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one scan tick of the timer: countdown, button edges, digit decode, scan advance
    function automatic display_t advance_timer(input logic [BTN_W-1:0] levels, input logic tick);
        display_t         r;
        logic [BTN_W-1:0] fell;
        logic [POS_W-1:0] top;
        int unsigned      shown;
        int               i;
        if (tick && tm_running)
            tm_seconds = tm_seconds - 1'b1;
        if (tm_seconds == '0)
            tm_running = 1'b0;
        fell = tm_prev_levels & ~levels;
        tm_prev_levels = levels;
        if (fell[BTN_START] && !tm_running && tm_seconds != tm_preset)
            tm_running = 1'b1;
        if (fell[BTN_PLUS1] && !tm_running)
            tm_seconds = tm_seconds + 16'd1;
        if (fell[BTN_PLUS10] && !tm_running)
            tm_seconds = tm_seconds + 16'd10;
        if (fell[BTN_RESET])
        begin
            tm_running = 1'b0;
            tm_seconds = tm_preset;
        end
        shown = tm_seconds % 10000;
        for (i = 0; i < int'(tm_scan); i++)
            shown = shown / 10;
        r.seg = DIGIT_SEGS[shown % 10];
        r.en  = 4'b1000 >> tm_scan;
        r.sec = tm_seconds;
        r.cnt = tm_running;
        top = (tm_max_scan > MAX_POS) ? MAX_POS : tm_max_scan;
        tm_scan = (tm_scan >= top) ? '0 : tm_scan + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned want);
        if (err_count < 40)
            $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
        err_count++;
    endtask

    // directed table rows
    function automatic dir_row_t item_row(input logic [BTN_W-1:0] lv, input logic tk);
        dir_row_t r;
        r = '{ROW_ITEM, lv, tk, CFG_MAX_SCAN, '0, '0};
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic [BTN_W-1:0] lv, input logic tk,
                                           input logic [SEG_W-1:0] seg, input logic [EN_W-1:0] en,
                                           input logic [SEC_W-1:0] sec, input logic cnt);
        dir_row_t r;
        r = '{ROW_TYPED, lv, tk, CFG_MAX_SCAN, '0, '{seg, en, sec, cnt}};
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic idx, input logic [CFG_W-1:0] val);
        dir_row_t r;
        r = '{ROW_CFG, LEVELS_IDLE, 1'b0, idx, val, '0};
        return r;
    endfunction

    // present one transaction, wait for acceptance, record its expected display
    task automatic send_scan(input logic [BTN_W-1:0] lv, input logic tk, input logic typed,
                             input display_t want);
        display_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        button_levels <= lv;
        second_tick   <= tk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = advance_timer(lv, tk);
        pending_displays.push_back(typed ? want : predicted);
    endtask

    // register write once every pending display has come out
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MAX_SCAN)
            tm_max_scan = val[POS_W-1:0];
        else
            tm_preset = val;
    endtask

    // output side: random stall and compare each accepted transaction
    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_displays.size() == 0)
                report_mismatch("unexpected transaction, seconds_value", seconds_value, 0);
            else
            begin
                want = pending_displays.pop_front();
                if (segment_pattern !== want.seg)
                    report_mismatch("segment_pattern", segment_pattern, want.seg);
                if (digit_enable !== want.en)
                    report_mismatch("digit_enable", digit_enable, want.en);
                if (seconds_value !== want.sec)
                    report_mismatch("seconds_value", seconds_value, want.sec);
                if (counting_flag !== want.cnt)
                    report_mismatch("counting_flag", counting_flag, want.cnt);
            end
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main stimulus
    initial
    begin
        dir_row_t         row;
        logic [BTN_W-1:0] lv;
        logic             tk;
        int               blk;
        int               n;
        int               pick;
        logic [CFG_W-1:0] preset_val;

        tm_seconds     = '0;
        tm_running     = 1'b0;
        tm_prev_levels = LEVELS_IDLE;
        tm_scan        = '0;
        tm_max_scan    = MAX_POS_RESET;
        tm_preset      = PRESET_RESET;

        // after reset, refused start, plus ten, plus one, start, plus one while counting
        dir_rows.push_back(typed_row(4'hF, 1'b0, 7'h3F, 4'h8, 16'd0, 1'b0));
        dir_rows.push_back(typed_row(4'hF, 1'b1, 7'h3F, 4'h4, 16'd0, 1'b0));
        dir_rows.push_back(typed_row(4'hD, 1'b0, 7'h3F, 4'h2, 16'd0, 1'b0));
        dir_rows.push_back(typed_row(4'hF, 1'b0, 7'h3F, 4'h1, 16'd0, 1'b0));
        dir_rows.push_back(typed_row(4'h7, 1'b0, 7'h3F, 4'h8, 16'd10, 1'b0));
        dir_rows.push_back(typed_row(4'hF, 1'b0, 7'h06, 4'h4, 16'd10, 1'b0));
        dir_rows.push_back(typed_row(4'hB, 1'b0, 7'h3F, 4'h2, 16'd11, 1'b0));
        dir_rows.push_back(typed_row(4'hF, 1'b0, 7'h3F, 4'h1, 16'd11, 1'b0));
        dir_rows.push_back(typed_row(4'hD, 1'b0, 7'h06, 4'h8, 16'd11, 1'b1));
        dir_rows.push_back(typed_row(4'hB, 1'b0, 7'h06, 4'h4, 16'd11, 1'b1));
        // countdown, plus ten ignored while counting, reset button
        dir_rows.push_back(item_row(4'hF, 1'b1));
        dir_rows.push_back(item_row(4'hF, 1'b1));
        dir_rows.push_back(item_row(4'h7, 1'b0));
        dir_rows.push_back(item_row(4'hE, 1'b0));
        // largest preset: start refused at preset, plus one wraps to zero, start from zero wraps
        dir_rows.push_back(cfg_row(CFG_PRESET, 16'hFFFF));
        dir_rows.push_back(item_row(4'hF, 1'b0));
        dir_rows.push_back(item_row(4'hE, 1'b0));
        dir_rows.push_back(item_row(4'hD, 1'b0));
        dir_rows.push_back(item_row(4'hB, 1'b0));
        dir_rows.push_back(item_row(4'hD, 1'b0));
        dir_rows.push_back(item_row(4'hF, 1'b1));
        // every edge at once with a tick
        dir_rows.push_back(item_row(4'h0, 1'b1));
        // lowered scan maximum, start blocking plus one and plus ten in the same transaction
        dir_rows.push_back(cfg_row(CFG_PRESET, 16'd5));
        dir_rows.push_back(cfg_row(CFG_MAX_SCAN, 16'd0));
        dir_rows.push_back(item_row(4'hF, 1'b0));
        dir_rows.push_back(item_row(4'h1, 1'b0));
        dir_rows.push_back(cfg_row(CFG_MAX_SCAN, 16'd1));
        dir_rows.push_back(item_row(4'hF, 1'b1));
        // countdown reaching zero stops counting
        dir_rows.push_back(cfg_row(CFG_PRESET, 16'd0));
        dir_rows.push_back(cfg_row(CFG_MAX_SCAN, 16'd3));
        dir_rows.push_back(item_row(4'hE, 1'b0));
        dir_rows.push_back(item_row(4'hB, 1'b0));
        dir_rows.push_back(item_row(4'hD, 1'b0));
        dir_rows.push_back(item_row(4'hF, 1'b1));
        dir_rows.push_back(item_row(4'hF, 1'b1));

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG)
                write_reg(row.reg_index, row.reg_value);
            else
                send_scan(row.levels, row.tick, row.kind == ROW_TYPED, row.want);
        end

        // random blocks, four idling phases of four blocks each
        for (blk = 0; blk < 16; blk++)
        begin
            case (blk / 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            pick = $urandom_range(5);
            case (pick)
                0:       preset_val = 16'd0;
                1:       preset_val = 16'hFFFF;
                2:       preset_val = 16'($urandom_range(30, 1));
                3:       preset_val = $urandom_range(1) ? 16'd9999 : 16'd10000;
                4:       preset_val = 16'($urandom_range(65535));
                default: preset_val = 16'($urandom_range(2000, 100));
            endcase
            // junk in the unused upper bits of the scan register write
            write_reg(CFG_MAX_SCAN, {14'($urandom_range(16383)),
                      (blk < 4) ? 2'(3 - blk) : 2'($urandom_range(3))});
            write_reg(CFG_PRESET, preset_val);
            for (n = 0; n < 85; n++)
            begin
                pick = $urandom_range(99);
                lv = LEVELS_IDLE;
                if (pick >= 45 && pick < 82)
                    lv[$urandom_range(BTN_W - 1)] = 1'b0;
                else if (pick >= 82)
                    lv = 4'($urandom_range(15));
                tk = ($urandom_range(99) < 55);
                send_scan(lv, tk, 1'b0, '0);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
